@@ rtl/core/grbf_pkg.sv @@
// ----------------------------------------------------------------------------
// grbf_pkg
// Shared types and constants of the Gaussian RBF activation engine.
// ----------------------------------------------------------------------------
package grbf_pkg;

	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [22:0] Q_LIMIT  = 23'h05_0000;

	typedef enum logic [1:0] {
		REG_BASIS_COUNT = 2'd0,
		REG_DIM_COUNT   = 2'd1,
		REG_NORMALIZE   = 2'd2,
		REG_ASYMMETRIC  = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,       // issue table reads for (b,d)
		ST_RD2,      // read of previous basis width
		ST_DIV,      // a<<16 / w, bit serial
		ST_SQ,       // u = q*q>>7
		ST_HORN_M,   // p*u>>30
		ST_HORN_D,   // /k by reciprocal
		ST_POW,      // four squarings
		ST_PROD,     // prod*factor
		ST_ACT,      // round, write scratch
		ST_OUT_RD,   // read scratch
		ST_OUT_DIV,  // normalize division
		ST_OUT       // present beat
	} state_t;

endpackage

@@ rtl/core/grbf_ram.sv @@
// ----------------------------------------------------------------------------
// grbf_ram
// Generic single port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module grbf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ rtl/core/grbf_div.sv @@
// ----------------------------------------------------------------------------
// grbf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grbf_div #(
	parameter int NW = 48,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   r_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [DW:0]   r_sh;
	logic          ge;

	assign r_sh = {r_q[DW-1:0], n_q[NW-1]};
	assign ge   = r_sh >= {1'b0, d_q};
	assign quo  = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (run_q) begin
			r_q <= ge ? (r_sh - {1'b0, d_q}) : r_sh;
			n_q <= {n_q[NW-2:0], ge};
		end
	end
endmodule

@@ rtl/core/grbf_cfg.sv @@
// ----------------------------------------------------------------------------
// grbf_cfg
// APB register file: basis count, dimension count, mode bits.
// ----------------------------------------------------------------------------
module grbf_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic [4:0]  basis_count_q,
	output logic [2:0]  dim_count_q,
	output logic        normalize_q,
	output logic        asymmetric_q
);
	import grbf_pkg::*;

	reg_idx_t idx;
	assign idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_count_q <= 5'd1;
			dim_count_q   <= 3'd1;
			normalize_q   <= 1'b0;
			asymmetric_q  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_BASIS_COUNT: basis_count_q <= pwdata[4:0];
				REG_DIM_COUNT:   dim_count_q   <= pwdata[2:0];
				REG_NORMALIZE:   normalize_q   <= pwdata[0];
				REG_ASYMMETRIC:  asymmetric_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_BASIS_COUNT: prdata = {27'd0, basis_count_q};
			REG_DIM_COUNT:   prdata = {29'd0, dim_count_q};
			REG_NORMALIZE:   prdata = {31'd0, normalize_q};
			REG_ASYMMETRIC:  prdata = {31'd0, asymmetric_q};
			default:         prdata = '0;
		endcase
	end
endmodule

@@ rtl/core/gaussian_rbf_activation_engine_top.sv @@
// ----------------------------------------------------------------------------
// gaussian_rbf_activation_engine_top
// Gaussian RBF layer: table of centers/widths in RAM, one activation beat
// per basis function for each sample, optional normalization.
// ----------------------------------------------------------------------------
//  channel | handshake       | payload
//  in      | in_valid/stall  | command, entry_index, dim_index, center/width,
//          |                 | coord_0..coord_3
//  out     | out_valid/stall | basis_index, activation, last
//  cfg     | APB             | basis_count, dim_count, normalize, asymmetric
//
// A load beat does not leave ST_IDLE, so the input is free again at once.
// After the accepting cycle a sample visits each (basis, dimension) pair in
// turn: table reads in ST_RD and ST_RD2, the bit-serial divider for the
// ratio, one square, 12 Horner steps of a multiply and a divide, four
// squarings and one product; when the last dimension of a basis is done,
// its activation is stored in scratch. Each output beat first reads scratch
// and, in normalized mode, runs one more division before it is presented.
// Reset clears control state only; table entries are undefined until loaded.
// A stalled output beat holds; no input is taken until the last beat leaves.
// ----------------------------------------------------------------------------
module gaussian_rbf_activation_engine_top #(
	parameter int MAX_BASIS = 16,
	parameter int MAX_DIMS  = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [3:0]  entry_index,
	input  logic [1:0]  dim_index,
	input  logic signed [31:0] center_value,
	input  logic [30:0] width_value,
	input  logic signed [31:0] coord_0,
	input  logic signed [31:0] coord_1,
	input  logic signed [31:0] coord_2,
	input  logic signed [31:0] coord_3,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  basis_index,
	output logic [16:0] activation,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import grbf_pkg::*;

	localparam int DEPTH = MAX_BASIS * MAX_DIMS;
	localparam int AW    = $clog2(DEPTH);
	localparam int BW    = $clog2(MAX_BASIS + 1);
	localparam int SW    = (MAX_BASIS > 1) ? $clog2(MAX_BASIS) : 1;

	logic [4:0] basis_count_q;
	logic [2:0] dim_count_q;
	logic       normalize_q, asymmetric_q;

	assign pready = 1'b1;

	grbf_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.basis_count_q, .dim_count_q, .normalize_q, .asymmetric_q
	);

	state_t state_q, state_d;

	// effective counts
	logic [BW-1:0] nb;
	logic [2:0]    nd;
	always_comb begin
		if (basis_count_q == 5'd0)                   nb = BW'(1);
		else if (32'(basis_count_q) > MAX_BASIS)     nb = BW'(MAX_BASIS);
		else                                         nb = BW'(basis_count_q);
		if (dim_count_q == 3'd0)                     nd = 3'd1;
		else if (32'(dim_count_q) > MAX_DIMS)        nd = 3'(MAX_DIMS);
		else                                         nd = dim_count_q;
	end

	logic [SW-1:0] b_q;
	logic [1:0]    d_q;
	logic signed [31:0] x_q [4];
	logic [3:0]    k_q;
	logic [2:0]    sqn_q;
	logic [18:0]   q_q;
	logic          zero_q;
	logic [29:0]   u_q;
	logic [29:0]   t_q;
	logic [30:0]   p_q;
	logic [30:0]   prod_q;
	logic [35:0]   sum_q;
	logic [16:0]   act_q;
	logic          single_q;
	logic          busy_q;

	// table RAMs
	logic            tbl_we;
	logic [AW-1:0]   tbl_addr;
	logic [31:0]     c_rd;
	logic [30:0]     w_rd;
	logic [31:0]     c_s1;
	logic [30:0]     w_s1;

	logic load_ok;
	assign load_ok = (32'(entry_index) < MAX_BASIS) && (32'(dim_index) < MAX_DIMS);

	logic in_acc;
	logic scr_we;
	logic dv_start;
	assign in_acc = in_valid && !in_stall;
	assign tbl_we = in_acc && !command && load_ok;

	function automatic logic [AW-1:0] taddr(input logic [SW-1:0] b, input logic [1:0] d);
		taddr = AW'(32'(b) * MAX_DIMS + 32'(d));
	endfunction

	// ceil(2^34 / k), exact floor division for dividends below 2^30
	function automatic logic [33:0] recip_k(input logic [3:0] k);
		unique case (k)
			4'd2:    recip_k = 34'h2_0000_0000;
			4'd3:    recip_k = 34'h1_5555_5556;
			4'd4:    recip_k = 34'h1_0000_0000;
			4'd5:    recip_k = 34'h0_CCCC_CCCD;
			4'd6:    recip_k = 34'h0_AAAA_AAAB;
			4'd7:    recip_k = 34'h0_9249_2493;
			4'd8:    recip_k = 34'h0_8000_0000;
			4'd9:    recip_k = 34'h0_71C7_1C72;
			4'd10:   recip_k = 34'h0_6666_6667;
			4'd11:   recip_k = 34'h0_5D17_45D2;
			4'd12:   recip_k = 34'h0_5555_5556;
			default: recip_k = '0;
		endcase
	endfunction

	always_comb begin
		if (tbl_we)                tbl_addr = AW'(32'(entry_index) * MAX_DIMS + 32'(dim_index));
		else if (state_q == ST_RD2) tbl_addr = taddr(b_q - 1'b1, d_q);
		else                       tbl_addr = taddr(b_q, d_q);
	end

	grbf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_center (
		.clk, .we(tbl_we), .addr(tbl_addr), .wdata(center_value), .rdata(c_rd)
	);
	grbf_ram #(.WIDTH(31), .DEPTH(DEPTH)) u_width (
		.clk, .we(tbl_we), .addr(tbl_addr), .wdata(width_value), .rdata(w_rd)
	);

	// scratch RAM
	logic [16:0] scr_rd;
	logic [16:0] scr_wdata;
	logic [16:0] rnd_act;
	assign rnd_act   = 17'((prod_q + 31'd8192) >> 14);
	assign scr_wdata = single_q ? 17'd65536 : rnd_act;
	grbf_ram #(.WIDTH(17), .DEPTH(MAX_BASIS)) u_scratch (
		.clk, .we(scr_we), .addr(b_q), .wdata(scr_wdata), .rdata(scr_rd)
	);

	// shared divider
	logic        dv_done;
	logic [47:0] dv_num, dv_quo;
	logic [35:0] dv_den;
	grbf_div #(.NW(48), .DW(36)) u_div (
		.clk, .arst_n, .start(dv_start), .num(dv_num), .den(dv_den),
		.done(dv_done), .quo(dv_quo)
	);

	// distance for the current dimension
	logic signed [32:0] diff;
	logic [31:0]        absd;
	logic               left;
	logic [30:0]        w_sel;
	assign diff  = 33'(x_q[d_q]) - 33'($signed(c_s1));
	assign left  = diff[32];
	assign absd  = left ? 32'(-diff) : 32'(diff);
	// left of center, take the width of the previous basis (read in ST_RD2)
	assign w_sel = (asymmetric_q && left && (b_q != '0)) ? w_rd : w_s1;

	logic [63:0] sq_full;
	logic [63:0] recip_full;
	logic [29:0] horn_quo;
	logic [30:0] factor;
	assign sq_full    = 64'(p_q) * 64'(p_q);
	assign recip_full = 64'(t_q) * 64'(recip_k(k_q));
	assign horn_quo   = (k_q == 4'd1) ? t_q : 30'(recip_full >> 34);
	assign factor     = zero_q ? '0 : p_q;

	logic last_d, last_b;
	assign last_d = ({1'b0, d_q} == nd - 3'd1);
	assign last_b = (BW'(b_q) == nb - 1'b1);

	logic norm_on;
	assign norm_on = normalize_q && (nb > BW'(1));

	always_comb begin
		dv_num = '0;
		dv_den = '0;
		if (state_q == ST_DIV) begin
			dv_num = {absd, 16'd0};
			dv_den = 36'((w_sel == 31'd0) ? 31'd1 : w_sel);
		end else if (state_q == ST_OUT_DIV) begin
			dv_num = 48'({scr_rd, 16'd0}) + 48'(sum_q >> 1);
			dv_den = sum_q;
		end
	end

	// outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
		scr_we    = (state_q == ST_ACT);
		dv_start  = !busy_q && (state_q == ST_DIV || state_q == ST_OUT_DIV);
	end

	assign basis_index = 4'(b_q);
	assign activation  = norm_on ? act_q : scr_rd;
	assign last        = last_b;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (in_acc && command) state_d = ST_RD;
			ST_RD:      state_d = ST_RD2;
			ST_RD2:     state_d = ST_DIV;
			ST_DIV:     if (busy_q && dv_done) state_d = ST_SQ;
			ST_SQ:      state_d = ST_HORN_M;
			ST_HORN_M:  state_d = ST_HORN_D;
			ST_HORN_D:  state_d = (k_q == 4'd1) ? ST_POW : ST_HORN_M;
			ST_POW:     if (sqn_q == 3'd4) state_d = ST_PROD;
			ST_PROD:    state_d = last_d ? ST_ACT : ST_RD;
			ST_ACT:     state_d = last_b ? ST_OUT_RD : ST_RD;
			ST_OUT_RD:  state_d = norm_on ? ST_OUT_DIV : ST_OUT;
			ST_OUT_DIV: if (busy_q && dv_done) state_d = ST_OUT;
			ST_OUT:     if (!out_stall) state_d = last_b ? ST_IDLE : ST_OUT_RD;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != state_d) busy_q <= 1'b0;
			else if (state_q == ST_DIV || state_q == ST_OUT_DIV)
				busy_q <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				x_q[0] <= coord_0; x_q[1] <= coord_1;
				x_q[2] <= coord_2; x_q[3] <= coord_3;
				b_q    <= '0;
				d_q    <= '0;
				sum_q  <= '0;
				prod_q <= ONE_Q30;
				single_q <= normalize_q && (nb == BW'(1));
			end
			ST_RD2: begin
				c_s1 <= c_rd;
				w_s1 <= w_rd;
			end
			ST_DIV: if (busy_q && dv_done) begin
				q_q    <= dv_quo[18:0];
				zero_q <= (dv_quo >= 48'(Q_LIMIT));
			end
			ST_SQ: begin
				u_q   <= 30'((38'(q_q) * 38'(q_q)) >> 7);
				p_q   <= ONE_Q30;
				k_q   <= 4'd12;
				sqn_q <= '0;
			end
			ST_HORN_M: t_q <= 30'((61'(p_q) * 61'(u_q)) >> 30);
			ST_HORN_D: begin
				p_q <= ONE_Q30 - 31'(horn_quo);
				k_q <= k_q - 1'b1;
			end
			ST_POW: if (sqn_q != 3'd4) begin
				p_q   <= 31'(sq_full >> 30);
				sqn_q <= sqn_q + 1'b1;
			end
			ST_PROD: begin
				prod_q <= 31'((62'(prod_q) * 62'(factor)) >> 30);
				d_q    <= d_q + 1'b1;
			end
			ST_ACT: begin
				sum_q  <= sum_q + 36'(scr_wdata);
				b_q    <= last_b ? '0 : b_q + 1'b1;
				d_q    <= '0;
				prod_q <= ONE_Q30;
			end
			ST_OUT_DIV: if (dv_done && busy_q) act_q <= (sum_q == 36'd0) ? 17'd0 : 17'(dv_quo);
			ST_OUT: if (!out_stall) b_q <= b_q + 1'b1;
			default: ;
		endcase
	end
endmodule

@@ tb/sv/gaussian_rbf_activation_engine_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_rbf_activation_engine_checker
// Watches the sample, activation and register channels, keeps its own copy
// of the center/width table and of the registers, predicts every activation
// beat and compares it field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module gaussian_rbf_activation_engine_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        command,
	input  logic [3:0]  entry_index,
	input  logic [1:0]  dim_index,
	input  logic [31:0] center_value,
	input  logic [30:0] width_value,
	input  logic [31:0] coord_0,
	input  logic [31:0] coord_1,
	input  logic [31:0] coord_2,
	input  logic [31:0] coord_3,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  basis_index,
	input  logic [16:0] activation,
	input  logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          errors,
	output int          pending,
	output int          in_beats,
	output int          out_beats
);
	import grbf_pkg::*;

	localparam longint unsigned UNIT_Q30 = 64'd1 << 30;

	typedef struct packed {
		logic [3:0]  idx;
		logic [16:0] act;
		logic        lst;
	} act_beat_t;

	act_beat_t   act_q[$];
	logic [31:0] centers[64];
	logic [30:0] widths[64];
	logic [4:0]  basis_cfg;
	logic [2:0]  dim_cfg;
	logic        norm_cfg;
	logic        asym_cfg;

	// exp(-0.5*(a/w)^2) in Q1.30
	function automatic longint unsigned gauss_q30(longint unsigned a, longint unsigned w);
		longint unsigned q, u, p;
		int k;
		if (w == 0) w = 1;
		q = (a << 16) / w;
		if (q >= (64'd5 << 16)) return 0;
		u = (q * q) >> 7;
		p = UNIT_Q30;
		for (k = 12; k >= 1; k--)
			p = UNIT_Q30 - ((p * u) >> 30) / longint'(k);
		for (k = 0; k < 4; k++)
			p = (p * p) >> 30;
		return p;
	endfunction

	task automatic predict_activations(input logic [3:0][31:0] crd);
		int nb, nd;
		longint unsigned prod, sum, v, w, a;
		longint signed x, c;
		longint unsigned acts[16];
		act_beat_t e;
		nb = basis_cfg;
		nd = dim_cfg;
		if (nb < 1) nb = 1;
		if (nb > 16) nb = 16;
		if (nd < 1) nd = 1;
		if (nd > 4) nd = 4;
		sum = 0;
		for (int b = 0; b < nb; b++) begin
			if (norm_cfg && nb == 1) begin
				acts[b] = 65536;
			end else begin
				prod = UNIT_Q30;
				for (int d = 0; d < nd; d++) begin
					x = $signed(crd[d]);
					c = $signed(centers[b*4+d]);
					w = widths[b*4+d];
					a = (x >= c) ? longint'(x - c) : longint'(c - x);
					// left of center, take the width of the previous basis
					if (asym_cfg && x < c && b > 0)
						w = widths[(b-1)*4+d];
					prod = (prod * gauss_q30(a, w)) >> 30;
				end
				acts[b] = (prod + 64'd8192) >> 14;
				sum += acts[b];
			end
		end
		for (int b = 0; b < nb; b++) begin
			v = acts[b];
			if (norm_cfg && nb > 1)
				v = (sum == 0) ? 0 : (v * 65536 + sum / 2) / sum;
			e.idx = b[3:0];
			e.act = v[16:0];
			e.lst = (b == nb - 1);
			act_q.push_back(e);
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		in_beats = 0;
		out_beats = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		act_beat_t e;
		if (!arst_n) begin
			basis_cfg = 5'd1;
			dim_cfg = 3'd1;
			norm_cfg = 1'b0;
			asym_cfg = 1'b0;
			act_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_BASIS_COUNT: basis_cfg = pwdata[4:0];
					REG_DIM_COUNT:   dim_cfg = pwdata[2:0];
					REG_NORMALIZE:   norm_cfg = pwdata[0];
					REG_ASYMMETRIC:  asym_cfg = pwdata[0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				in_beats++;
				if (command == 1'b0) begin
					centers[{entry_index, dim_index}] = center_value;
					widths[{entry_index, dim_index}] = width_value;
				end else begin
					predict_activations({coord_3, coord_2, coord_1, coord_0});
				end
			end
			if (out_valid && !out_stall) begin
				out_beats++;
				if (act_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: activation beat with nothing expected: idx %0d act %0d last %0b",
							$realtime, basis_index, activation, last);
					errors++;
				end else begin
					e = act_q.pop_front();
					if (e.idx !== basis_index || e.act !== activation || e.lst !== last) begin
						if (errors < 10)
							$display("%0t: mismatch exp idx %0d act %0d last %0b, got idx %0d act %0d last %0b",
								$realtime, e.idx, e.act, e.lst, basis_index, activation, last);
						errors++;
					end
				end
			end
		end
		pending = act_q.size();
	end

endmodule

@@ tb/sv/gaussian_rbf_activation_engine_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gaussian_rbf_activation_engine_top_tb
// Fills the basis table, then runs register phases (normal, normalized,
// asymmetric, clamped counts, largest sizes) with directed and random load
// and sample beats under random idling on both channels, bar the last two.
// ----------------------------------------------------------------------------
module gaussian_rbf_activation_engine_top_tb;
	import grbf_pkg::*;

	typedef struct packed {
		logic             cmd;
		logic [3:0]       e;
		logic [1:0]       di;
		logic [31:0]      cv;
		logic [30:0]      wv;
		logic [3:0][31:0] crd;
	} stim_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        command = 0;
	logic [3:0]  entry_index = 0;
	logic [1:0]  dim_index = 0;
	logic [31:0] center_value = 0;
	logic [30:0] width_value = 0;
	logic [31:0] coord_0 = 0, coord_1 = 0, coord_2 = 0, coord_3 = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [3:0]  basis_index;
	logic [16:0] activation;
	logic        last;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [3:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;

	int errors, pending, in_beats, out_beats;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int nb_eff, nd_eff;
	logic [31:0] cen_mirror[64];
	logic [30:0] wid_mirror[64];

	// phase table: basis_count, dim_count, normalize, asymmetric, random beats
	int ph_basis[8] = '{3, 1, 16, 4, 2, 0, 20, 5};
	int ph_dims[8]  = '{2, 1, 4, 2, 3, 0, 7, 1};
	int ph_norm[8]  = '{0, 1, 1, 1, 0, 1, 0, 1};
	int ph_asym[8]  = '{0, 0, 1, 1, 1, 1, 0, 0};
	int ph_beats[8] = '{45, 30, 4, 60, 60, 30, 3, 48};

	always #5 clk = ~clk;

	gaussian_rbf_activation_engine_top DUT (.*);

	gaussian_rbf_activation_engine_checker u_checker (.*);

	always @(negedge clk)
		out_stall = ($urandom_range(99) < recv_stall_pct);

	task automatic drive_beat(input stim_t s);
		int seen;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		command = s.cmd;
		entry_index = s.e;
		dim_index = s.di;
		center_value = s.cv;
		width_value = s.wv;
		{coord_3, coord_2, coord_1, coord_0} = s.crd;
		if (!s.cmd) begin
			cen_mirror[{s.e, s.di}] = s.cv;
			wid_mirror[{s.e, s.di}] = s.wv;
		end
		in_valid = 1;
		seen = in_beats;
		do @(negedge clk); while (in_beats == seen);
		in_valid = 0;
	endtask

	task automatic load_entry(input logic [3:0] e, input logic [1:0] di,
			input logic [31:0] cv, input logic [30:0] wv);
		stim_t s;
		s = '0;
		s.e = e;
		s.di = di;
		s.cv = cv;
		s.wv = wv;
		drive_beat(s);
	endtask

	task automatic sample(input logic [3:0][31:0] crd);
		stim_t s;
		s = '0;
		s.cmd = 1;
		s.e = 4'($urandom);
		s.di = 2'($urandom);
		s.crd = crd;
		drive_beat(s);
	endtask

	function automatic logic [31:0] rand_center();
		if ($urandom_range(9) == 0) return $urandom;
		return $urandom_range(0, 32'h20_0000) - 32'h10_0000;
	endfunction

	function automatic logic [30:0] rand_width();
		int r;
		r = $urandom_range(19);
		if (r == 0) return 31'd0;
		if (r == 1) return 31'($urandom);
		if (r == 2) return 31'($urandom_range(1, 255));
		return 31'($urandom_range(32'h4000, 32'h8_0000));
	endfunction

	task automatic random_beat();
		logic [3:0][31:0] crd;
		longint signed span, off;
		int b;
		if ($urandom_range(99) < 40) begin
			load_entry(4'($urandom), 2'($urandom), rand_center(), rand_width());
		end else if ($urandom_range(99) < 20) begin
			sample({$urandom, $urandom, $urandom, $urandom});
		end else begin
			// aim the coordinates around one basis function
			b = $urandom_range(0, nb_eff - 1);
			for (int d = 0; d < 4; d++) begin
				span = 3 * longint'(wid_mirror[b*4+d]) + 1;
				off = longint'($urandom_range(0, 32'hFFFF_FFFF)) % (2 * span + 1) - span;
				crd[d] = 32'($signed(cen_mirror[b*4+d]) + off);
				if (d >= nd_eff && $urandom_range(1)) crd[d] = $urandom;
			end
			sample(crd);
		end
	endtask

	task automatic reg_write(input reg_idx_t r, input logic [31:0] v);
		psel = 1;
		penable = 0;
		pwrite = 1;
		paddr = {r, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		// a trailing load may still be in progress
		repeat (10) @(negedge clk);
	endtask

	initial begin
		#100_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		// every entry gets written before any sample reads it
		for (int i = 0; i < 64; i++)
			load_entry(i[5:2], i[1:0], rand_center(), rand_width());
		for (int p = 0; p < 8; p++) begin
			send_idle_pct = (p < 3) ? 37 : (p < 6) ? 60 : 0;
			recv_stall_pct = (p < 3) ? 60 : (p < 6) ? 37 : 0;
			drain();
			reg_write(REG_BASIS_COUNT, ph_basis[p]);
			reg_write(REG_DIM_COUNT, ph_dims[p]);
			reg_write(REG_NORMALIZE, ph_norm[p]);
			reg_write(REG_ASYMMETRIC, ph_asym[p]);
			nb_eff = (ph_basis[p][4:0] < 1) ? 1 : (ph_basis[p][4:0] > 16) ? 16 : ph_basis[p][4:0];
			nd_eff = (ph_dims[p][2:0] < 1) ? 1 : (ph_dims[p][2:0] > 4) ? 4 : ph_dims[p][2:0];
			if (p == 0) begin
				// zero width, exact hit and one LSB off
				load_entry(4'd0, 2'd0, 32'd0, 31'd0);
				sample({32'd0, 32'd0, 32'd0, 32'd0});
				sample({32'd0, 32'd0, 32'd0, 32'd1});
				sample({4{32'h7FFF_FFFF}});
				sample({4{32'h8000_0000}});
				sample({cen_mirror[7], cen_mirror[6], cen_mirror[5], cen_mirror[4]});
				load_entry(4'd1, 2'd1, 32'h8000_0000, 31'h7FFF_FFFF);
				sample({32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000});
				load_entry(4'd15, 2'd3, 32'h7FFF_FFFF, 31'd1);
			end
			if (p == 1 || p == 3) begin
				// far from every center: single basis or zero sum
				sample({4{32'h7FFF_FFFF}});
				sample({4{32'h8000_0000}});
			end
			for (int i = 0; i < ph_beats[p]; i++)
				random_beat();
		end
		drain();
		repeat (50) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/grbf_pkg.sv
rtl/core/grbf_ram.sv
rtl/core/grbf_div.sv
rtl/core/grbf_cfg.sv
rtl/core/gaussian_rbf_activation_engine_top.sv
tb/sv/gaussian_rbf_activation_engine_checker.sv
tb/sv/gaussian_rbf_activation_engine_top_tb.sv
